### design/aas_pkg.sv
// shared types, constants and helpers of the autorange axis scaler
// no dependencies; used by every module of the block
package aas_pkg;

	// default number of stored axes
	localparam int NUM_AXES_DEF = 3;

	// axes that have wanted-range registers and output fields
	localparam int WANT_AXES = 3;

	// stream and configuration widths
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int VAL_W      = 16;

	// serial divider operand widths: 16 x 15 bit product over a 16 bit distance
	localparam int DIST_W    = 16;
	localparam int HALF_W    = 15;
	localparam int DIV_NUM_W = DIST_W + HALF_W;
	localparam int DIV_DEN_W = 16;

	// event types
	localparam logic [4:0] EVT_KEY = 5'd1;
	localparam logic [4:0] EVT_ABS = 5'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_MAX_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_MIN_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_MAX_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_MIN_Z = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WANT_MAX_Z = 3'd5;

	// wanted-range reset values
	localparam logic signed [VAL_W-1:0] WANT_MIN_RST = 16'sh8000;
	localparam logic signed [VAL_W-1:0] WANT_MAX_RST = 16'sh7FFF;

	// key codes that map onto each of the three buttons
	localparam logic [9:0] BTN_CODES [3][3] = '{
		'{10'h120, 10'h130, 10'h101},
		'{10'h121, 10'h131, 10'h102},
		'{10'h122, 10'h132, 10'h103}
	};

	// operands of one scaling request
	typedef struct packed {
		logic [DIST_W-1:0]    delta;
		logic [HALF_W-1:0]    hmag;
		logic [DIV_DEN_W-1:0] den;
		logic                 neg;
	} scale_req_t;

	// buttons whose key codes match
	function automatic logic [2:0] btn_hit(input logic [9:0] code);
		logic [2:0] hit;
		hit = '0;
		for (int b = 0; b < 3; b++) begin
			for (int k = 0; k < 3; k++) begin
				if (code == BTN_CODES[b][k]) hit[b] = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

### design/aas_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on aas_pkg for default widths
module aas_div #(
	parameter int NUM_W = aas_pkg::DIV_NUM_W,
	parameter int DEN_W = aas_pkg::DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// iteration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				den_q  <= divisor;
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q <= {quo_q[NUM_W-2:0], ge};
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/aas_scale.sv
// scaling sequencer: multiply, serial divide, sign and saturate
// depends on aas_pkg and aas_div
module aas_scale (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  aas_pkg::scale_req_t      req,
	output logic                     done,
	output logic signed [15:0]       result
);
	import aas_pkg::*;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_MUL,
		SC_DIVS,
		SC_DIVW,
		SC_SAT
	} sc_state_t;

	sc_state_t            state_q;
	scale_req_t           req_q;
	logic [DIV_NUM_W-1:0] prod_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic                 div_start_q;
	logic                 done_q;
	logic signed [15:0]   result_q;

	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;
	logic [15:0]          sat_val;

	// serial divider
	aas_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_q),
		.divisor  (req_q.den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// apply sign and clamp to 16 bits
	always_comb begin
		if (req_q.neg) begin
			if (quo_q > DIV_NUM_W'(32768)) sat_val = 16'h8000;
			else sat_val = ~quo_q[15:0] + 16'd1;
		end else begin
			if (quo_q > DIV_NUM_W'(32767)) sat_val = 16'h7FFF;
			else sat_val = quo_q[15:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SC_IDLE;
			req_q       <= '0;
			prod_q      <= '0;
			quo_q       <= '0;
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
			unique case (state_q)
				SC_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= SC_MUL;
					end
				end
				SC_MUL: begin
					prod_q  <= req_q.delta * req_q.hmag;
					state_q <= SC_DIVS;
				end
				SC_DIVS: begin
					div_start_q <= 1'b1;
					state_q     <= SC_DIVW;
				end
				SC_DIVW: begin
					if (div_done) begin
						quo_q   <= div_quo;
						state_q <= SC_SAT;
					end
				end
				SC_SAT: begin
					result_q <= sat_val;
					done_q   <= 1'b1;
					state_q  <= SC_IDLE;
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### design/autorange_axis_scaler_core.sv
// Autorange axis scaler. Takes one event or calibration request at a time and
// returns one result holding the button mask, the three mapped axes and a
// handled flag. Key, calibration and ignored requests go straight to the output
// step; an absolute axis event first widens the seen extremes and, unless its
// range is degenerate, is scaled by the 31-step serial divider that follows
// the single 16 x 15 multiplier in the scaling sequencer. The next request is
// taken while a finished result still waits on the output; a result that
// cannot be moved into a full, undrained output register holds the block in
// its last step.
// depends on aas_pkg and aas_scale
module autorange_axis_scaler_core #(
	parameter int NUM_AXES = aas_pkg::NUM_AXES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request: tuser = mode
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// event_type, event_code, event_value, cal_axis, cal_center, cal_min, cal_max
	input  logic [aas_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// buttons, axis_x, axis_y, axis_z, handled
	output logic [aas_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aas_pkg::VAL_W-1:0]          cfg_data
);
	import aas_pkg::*;

	localparam int AXW    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int AX_LIM = (NUM_AXES < WANT_AXES) ? NUM_AXES : WANT_AXES;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic signed [VAL_W-1:0]  want_lo_q  [WANT_AXES];
	logic signed [VAL_W-1:0]  want_hi_q  [WANT_AXES];
	logic signed [VAL_W-1:0]  center_q   [NUM_AXES];
	logic signed [VAL_W-1:0]  raw_min_q  [NUM_AXES];
	logic signed [VAL_W-1:0]  raw_max_q  [NUM_AXES];
	logic signed [VAL_W-1:0]  seen_max_q [NUM_AXES];
	logic signed [VAL_W-1:0]  seen_min_q [NUM_AXES];
	logic signed [VAL_W-1:0]  mapped_q   [NUM_AXES];
	logic [2:0]               mask_q;
	logic                     handled_q;
	logic [AXW-1:0]           idx_q;
	logic [1:0]               wax_q;
	logic signed [VAL_W-1:0]  val_q;
	logic                     sc_start_q;
	scale_req_t               sc_req_q;
	logic                     ovalid_q;
	logic [OUT_DATA_W-1:0]    odata_q;

	// request fields
	logic                     in_mode;
	logic [4:0]               in_type;
	logic [9:0]               in_code;
	logic signed [VAL_W-1:0]  in_value;
	logic [1:0]               in_cal_axis;
	logic signed [VAL_W-1:0]  in_cal_center;
	logic signed [VAL_W-1:0]  in_cal_min;
	logic signed [VAL_W-1:0]  in_cal_max;

	assign in_mode       = s_axis_tuser;
	assign in_type       = s_axis_tdata[4:0];
	assign in_code       = s_axis_tdata[14:5];
	assign in_value      = s_axis_tdata[30:15];
	assign in_cal_axis   = s_axis_tdata[32:31];
	assign in_cal_center = s_axis_tdata[48:33];
	assign in_cal_min    = s_axis_tdata[64:49];
	assign in_cal_max    = s_axis_tdata[80:65];

	logic in_accept;
	logic [2:0] hit;
	logic out_load;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign hit           = btn_hit(in_code);
	assign cfg_ready     = 1'b1;
	assign out_load      = (state_q == ST_DONE) && (!ovalid_q || m_axis_tready);

	// axis step: widen seen extremes and form the scaling operands
	logic signed [VAL_W-1:0] mid;
	logic signed [VAL_W-1:0] smax_n;
	logic signed [VAL_W-1:0] smin_n;
	logic                    above;
	logic                    degen;
	logic signed [VAL_W:0]   dist17;
	logic signed [VAL_W:0]   den17;
	logic signed [VAL_W:0]   wdiff;
	logic [VAL_W:0]          wmag;
	scale_req_t              req_n;

	always_comb begin
		mid    = center_q[idx_q];
		smax_n = (val_q > seen_max_q[idx_q]) ? val_q : seen_max_q[idx_q];
		smin_n = (val_q < seen_min_q[idx_q]) ? val_q : seen_min_q[idx_q];
		above  = val_q > mid;
		degen  = (raw_min_q[idx_q] == raw_max_q[idx_q]) || (smin_n == smax_n) ||
			(smax_n == mid) || (smin_n == mid);
		dist17 = above ? (17'(val_q) - 17'(mid)) : (17'(mid) - 17'(val_q));
		den17  = above ? (17'(smax_n) - 17'(mid)) : (17'(mid) - 17'(smin_n));
		wdiff  = 17'(want_hi_q[wax_q]) - 17'(want_lo_q[wax_q]);
		wmag   = wdiff[VAL_W] ? 17'(-wdiff) : 17'(wdiff);
		req_n.delta = dist17[DIST_W-1:0];
		req_n.hmag  = wmag[HALF_W:1];
		req_n.den   = den17[DIV_DEN_W-1:0];
		req_n.neg   = wdiff[VAL_W] ^ ~above;
	end

	// scaling unit
	logic                    sc_done;
	logic signed [VAL_W-1:0] sc_result;

	aas_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start_q),
		.req    (sc_req_q),
		.done   (sc_done),
		.result (sc_result)
	);

	// axis outputs, zero where no axis is stored
	logic [VAL_W-1:0] axis_out [WANT_AXES];
	for (genvar i = 0; i < WANT_AXES; i++) begin : g_axis_out
		if (i < NUM_AXES) begin : g_on
			assign axis_out[i] = mapped_q[i];
		end else begin : g_off
			assign axis_out[i] = '0;
		end
	end

	// control, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int a = 0; a < WANT_AXES; a++) begin
				want_lo_q[a] <= WANT_MIN_RST;
				want_hi_q[a] <= WANT_MAX_RST;
			end
			for (int a = 0; a < NUM_AXES; a++) begin
				center_q[a]   <= '0;
				raw_min_q[a]  <= '0;
				raw_max_q[a]  <= '0;
				seen_max_q[a] <= '0;
				seen_min_q[a] <= '0;
				mapped_q[a]   <= '0;
			end
			mask_q     <= '0;
			handled_q  <= 1'b0;
			idx_q      <= '0;
			wax_q      <= '0;
			val_q      <= '0;
			sc_start_q <= 1'b0;
			sc_req_q   <= '0;
			ovalid_q   <= 1'b0;
			odata_q    <= '0;
		end else begin
			sc_start_q <= 1'b0;

			// wanted-range register writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WANT_MIN_X: want_lo_q[0] <= cfg_data;
					CFG_WANT_MAX_X: want_hi_q[0] <= cfg_data;
					CFG_WANT_MIN_Y: want_lo_q[1] <= cfg_data;
					CFG_WANT_MAX_Y: want_hi_q[1] <= cfg_data;
					CFG_WANT_MIN_Z: want_lo_q[2] <= cfg_data;
					CFG_WANT_MAX_Z: want_hi_q[2] <= cfg_data;
					default: ;
				endcase
			end

			// output register loads a finished result or drains
			if (out_load) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						handled_q <= 1'b0;
						state_q   <= ST_DONE;
						if (in_mode) begin
							if (in_cal_axis < 2'(AX_LIM)) begin
								center_q[in_cal_axis[AXW-1:0]]   <= in_cal_center;
								raw_min_q[in_cal_axis[AXW-1:0]]  <= in_cal_min;
								raw_max_q[in_cal_axis[AXW-1:0]]  <= in_cal_max;
								seen_max_q[in_cal_axis[AXW-1:0]] <= in_cal_min;
								seen_min_q[in_cal_axis[AXW-1:0]] <= in_cal_max;
								handled_q <= 1'b1;
							end
						end else if (in_type == EVT_KEY) begin
							for (int b = 0; b < 3; b++) begin
								if (hit[b]) mask_q[b] <= (in_value != '0);
							end
							handled_q <= |hit;
						end else if (in_type == EVT_ABS) begin
							if (in_code < 10'(AX_LIM)) begin
								idx_q     <= in_code[AXW-1:0];
								wax_q     <= in_code[1:0];
								val_q     <= in_value;
								handled_q <= 1'b1;
								state_q   <= ST_PREP;
							end
						end
					end
				end
				ST_PREP: begin
					seen_max_q[idx_q] <= smax_n;
					seen_min_q[idx_q] <= smin_n;
					if (degen) begin
						mapped_q[idx_q] <= val_q;
						state_q         <= ST_DONE;
					end else begin
						sc_req_q   <= req_n;
						sc_start_q <= 1'b1;
						state_q    <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (sc_done) begin
						mapped_q[idx_q] <= sc_result;
						state_q         <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						odata_q  <= {4'd0, handled_q, axis_out[2], axis_out[1],
							axis_out[0], mask_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;

endmodule

### test/aas_result_checker.sv
// result checker of the autorange axis scaler: watches the request, result and
// register channels, predicts each result and compares it field by field
// depends on aas_pkg
module aas_result_checker
	import aas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [VAL_W-1:0]      cfg_data,
	output int                    mismatches,
	output int                    pending
);

	// result fields, highest bit first
	typedef struct packed {
		logic               handled;
		logic signed [15:0] axis_z;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_x;
		logic [2:0]         buttons;
	} axis_report_t;

	// wanted output ranges
	logic signed [15:0] want_lo [WANT_AXES];
	logic signed [15:0] want_hi [WANT_AXES];
	// per-axis calibration and seen extremes
	logic signed [15:0] center  [WANT_AXES];
	logic signed [15:0] raw_lo  [WANT_AXES];
	logic signed [15:0] raw_hi  [WANT_AXES];
	logic signed [15:0] peak_hi [WANT_AXES];
	logic signed [15:0] peak_lo [WANT_AXES];
	logic signed [15:0] axis_val [WANT_AXES];
	logic [2:0]         btn_mask;

	axis_report_t awaited_reports [$];
	int error_count = 0;
	int pending_q = 0;

	assign mismatches = error_count;
	assign pending = pending_q;

	// widen the seen extremes, then scale the distance from the center
	function automatic logic signed [15:0] scale_sample(int a, logic signed [15:0] s);
		longint mid, v, half, num, den, q;
		mid = center[a];
		v = s;
		if (v > longint'(peak_hi[a])) peak_hi[a] = s;
		if (v < longint'(peak_lo[a])) peak_lo[a] = s;
		if (raw_lo[a] == raw_hi[a]) return s;
		if (peak_lo[a] == peak_hi[a] || peak_hi[a] == center[a] || peak_lo[a] == center[a])
			return s;
		half = (longint'(want_hi[a]) - longint'(want_lo[a])) / 2;
		if (v > mid) begin
			num = (v - mid) * half;
			den = longint'(peak_hi[a]) - mid;
		end else begin
			num = (mid - v) * half;
			den = longint'(peak_lo[a]) - mid;
		end
		if (den == 0) return s;
		q = num / den;
		if (q > 32767) q = 32767;
		else if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	// update the axis state for one request and return the report it causes
	function automatic axis_report_t apply_request(logic mode, logic [IN_DATA_W-1:0] d);
		logic [4:0]         etype;
		logic [9:0]         ecode;
		logic signed [15:0] evalue;
		logic [1:0]         caxis;
		axis_report_t       r;
		etype = d[4:0];
		ecode = d[14:5];
		evalue = d[30:15];
		caxis = d[32:31];
		r.handled = 1'b0;
		if (mode) begin
			if (caxis < WANT_AXES) begin
				center[caxis] = d[48:33];
				raw_lo[caxis] = d[64:49];
				raw_hi[caxis] = d[80:65];
				peak_hi[caxis] = d[64:49];
				peak_lo[caxis] = d[80:65];
				r.handled = 1'b1;
			end
		end else if (etype == EVT_KEY) begin
			for (int b = 0; b < 3; b++) begin
				for (int k = 0; k < 3; k++) begin
					if (ecode == BTN_CODES[b][k]) begin
						btn_mask[b] = (evalue != 0);
						r.handled = 1'b1;
					end
				end
			end
		end else if (etype == EVT_ABS) begin
			if (ecode < WANT_AXES) begin
				axis_val[ecode] = scale_sample(ecode, evalue);
				r.handled = 1'b1;
			end
		end
		r.buttons = btn_mask;
		r.axis_x = axis_val[0];
		r.axis_y = axis_val[1];
		r.axis_z = axis_val[2];
		return r;
	endfunction

	task automatic check_field(string name, longint want_v, longint got_v);
		if (want_v != got_v) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
			error_count++;
		end
	endtask

	// watch the channels: register writes, results, then requests
	always @(posedge clk or negedge arst_n) begin
		axis_report_t got, want;
		if (!arst_n) begin
			for (int a = 0; a < WANT_AXES; a++) begin
				want_lo[a] = WANT_MIN_RST;
				want_hi[a] = WANT_MAX_RST;
				center[a] = '0;
				raw_lo[a] = '0;
				raw_hi[a] = '0;
				peak_hi[a] = '0;
				peak_lo[a] = '0;
				axis_val[a] = '0;
			end
			btn_mask = '0;
			awaited_reports.delete();
			pending_q <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < 2 * WANT_AXES) begin
				if (cfg_index[0]) want_hi[cfg_index >> 1] = cfg_data;
				else want_lo[cfg_index >> 1] = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[51:0];
				if (awaited_reports.size() == 0) begin
					$display("%0t: result expected none got %h", $time, got);
					error_count++;
				end else begin
					want = awaited_reports.pop_front();
					check_field("buttons", want.buttons, got.buttons);
					check_field("axis_x", want.axis_x, got.axis_x);
					check_field("axis_y", want.axis_y, got.axis_y);
					check_field("axis_z", want.axis_z, got.axis_z);
					check_field("handled", want.handled, got.handled);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_reports.push_back(apply_request(s_axis_tuser, s_axis_tdata));
			pending_q <= awaited_reports.size();
		end
	end

endmodule

### test/tb_autorange_axis_scaler_core.sv
// testbench top of the autorange axis scaler: clock, reset, request and
// register stimulus, random idling and the verdict
// depends on aas_pkg, autorange_axis_scaler_core and aas_result_checker
module tb_autorange_axis_scaler_core;
	import aas_pkg::*;

	localparam logic       MODE_EVENT = 1'b0;
	localparam logic       MODE_CAL   = 1'b1;
	localparam logic [4:0] EVT_OTHER  = 5'd31;
	localparam logic [9:0] KEY_UNLISTED = 10'h3FF;
	localparam logic [9:0] ABS_X = 10'd0;
	localparam logic [9:0] ABS_Y = 10'd1;
	localparam logic [9:0] ABS_Z = 10'd2;
	localparam logic [9:0] ABS_UNLISTED = 10'd3;
	localparam logic [1:0] CAL_X = 2'd0;
	localparam logic [1:0] CAL_Y = 2'd1;
	localparam logic [1:0] CAL_Z = 2'd2;
	localparam logic [1:0] CAL_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam logic [CFG_IDX_W-1:0] WANT_MIN_REG [3] = '{
		CFG_WANT_MIN_X, CFG_WANT_MIN_Y, CFG_WANT_MIN_Z};
	localparam logic [CFG_IDX_W-1:0] WANT_MAX_REG [3] = '{
		CFG_WANT_MAX_X, CFG_WANT_MAX_Y, CFG_WANT_MAX_Z};
	localparam logic signed [15:0] NARROW_LO [3] = '{-16'sd100, 16'sd0, -16'sd3};
	localparam logic signed [15:0] NARROW_HI [3] = '{16'sd100, 16'sd0, 16'sd2};
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 165;
	localparam int HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [VAL_W-1:0]      cfg_data = '0;

	int mismatches;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_kick = 1'b0;
	logic hold_ack = 1'b0;
	int hold_left = 0;
	// calibrated range last sent per axis, used to aim samples
	int stim_lo [3] = '{0, 0, 0};
	int stim_hi [3] = '{0, 0, 0};

	autorange_axis_scaler_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	aas_result_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: random stalls, plus a long hold-off when kicked
	always @(posedge clk) begin
		if (hold_kick != hold_ack) begin
			hold_ack <= hold_kick;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [15:0] rand16();
		return 16'($urandom);
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_request(
		logic [4:0] etype, logic [9:0] ecode, logic [15:0] evalue, logic [1:0] caxis,
		logic [15:0] ccenter, logic [15:0] cmin, logic [15:0] cmax);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[80:0] = {cmax, cmin, ccenter, caxis, evalue, ecode, etype};
		return d;
	endfunction

	// offer one request after a random gap and wait for it to be taken
	task automatic send_request(input logic mode, input logic [IN_DATA_W-1:0] data);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// wanted ranges per phase: full, reversed, narrow or random
	task automatic load_wanted_ranges(input int phase);
		logic [15:0] lo, hi;
		for (int a = 0; a < 3; a++) begin
			case (phase)
				1: begin
					lo = WANT_MIN_RST;
					hi = WANT_MAX_RST;
				end
				2: begin
					lo = WANT_MAX_RST;
					hi = WANT_MIN_RST;
				end
				4: begin
					lo = NARROW_LO[a];
					hi = NARROW_HI[a];
				end
				default: begin
					lo = rand16();
					hi = rand16();
				end
			endcase
			write_reg(WANT_MIN_REG[a], lo);
			write_reg(WANT_MAX_REG[a], hi);
		end
		if (phase == RANDOM_PHASES) begin
			write_reg(CFG_SPARE_A, rand16());
			write_reg(CFG_SPARE_B, rand16());
		end
		cfg_valid <= 1'b0;
	endtask

	// mostly samples, most within the last calibrated range, plus calibrations, keys and noise
	task automatic make_random(output logic mode, output logic [IN_DATA_W-1:0] data);
		int pick, lo, hi, tmp, a;
		logic [9:0] code;
		logic [15:0] v;
		pick = $urandom_range(99);
		mode = MODE_EVENT;
		data = pack_request(5'($urandom), 10'($urandom), rand16(), 2'($urandom),
			rand16(), rand16(), rand16());
		if (pick < 12) begin
			a = $urandom_range(2);
			lo = int'($signed(rand16()));
			hi = int'($signed(rand16()));
			if (lo > hi) begin
				tmp = lo;
				lo = hi;
				hi = tmp;
			end
			if ($urandom_range(7) == 0) hi = lo;
			stim_lo[a] = lo;
			stim_hi[a] = hi;
			mode = MODE_CAL;
			data[32:31] = 2'(a);
			data[48:33] = 16'(lo + int'($urandom_range(hi - lo)));
			data[64:49] = 16'(lo);
			data[80:65] = 16'(hi);
		end else if (pick < 30) begin
			code = BTN_CODES[$urandom_range(2)][$urandom_range(2)];
			v = $urandom_range(1) ? 16'h0000 : rand16();
			data[4:0] = EVT_KEY;
			data[14:5] = code;
			data[30:15] = v;
		end else if (pick < 88) begin
			a = $urandom_range(2);
			if ($urandom_range(9) < 7)
				v = 16'(stim_lo[a] + int'($urandom_range(stim_hi[a] - stim_lo[a])));
			else
				v = rand16();
			data[4:0] = EVT_ABS;
			data[14:5] = 10'(a);
			data[30:15] = v;
		end else begin
			mode = 1'($urandom);
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic mode;
		logic [IN_DATA_W-1:0] data;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every button code, ignored items, calibration corners
		for (int b = 0; b < 3; b++) begin
			for (int k = 0; k < 3; k++) begin
				send_request(MODE_EVENT, pack_request(EVT_KEY, BTN_CODES[b][k],
					(k == 1) ? 16'h0000 : ((k == 0) ? 16'h7FFF : 16'h8000), CAL_X,
					16'h0000, 16'h0000, 16'h0000));
			end
		end
		send_request(MODE_EVENT, pack_request(EVT_KEY, KEY_UNLISTED, 16'h0001, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		send_request(MODE_EVENT, pack_request(EVT_OTHER, ABS_X, 16'h1234, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_UNLISTED, 16'h0100, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		// uncalibrated axis passes the raw sample
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_X, 16'h8000, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		send_request(MODE_CAL, pack_request(EVT_ABS, ABS_X, 16'h0000, CAL_NONE,
			16'h0010, 16'h8000, 16'h7FFF));
		send_request(MODE_CAL, pack_request(EVT_KEY, ABS_X, 16'h0000, CAL_X,
			16'h0000, 16'h8000, 16'h7FFF));
		// first sample leaves seen extremes equal, then full swing both sides
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_X, 16'h7FFF, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_X, 16'h8000, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_X, 16'h0000, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_X, 16'h4000, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		// seen extreme on the center passes through
		send_request(MODE_CAL, pack_request(EVT_ABS, ABS_Y, 16'h0000, CAL_Y,
			16'd100, -16'sd500, 16'sd700));
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_Y, 16'd100, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_Y, 16'd700, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_Y, -16'sd500, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		// raw minimum equal to raw maximum
		send_request(MODE_CAL, pack_request(EVT_ABS, ABS_Z, 16'h0000, CAL_Z,
			16'd5, 16'd7, 16'd7));
		send_request(MODE_EVENT, pack_request(EVT_ABS, ABS_Z, 16'd9, CAL_X,
			16'h0000, 16'h0000, 16'h0000));
		s_axis_tvalid <= 1'b0;

		// random phases, each reloading the wanted ranges and setting the idling
		for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
			wait_drained();
			load_wanted_ranges(phase);
			case (phase % 4)
				1: begin
					idle_pct = 61;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 61;
				end
				3: begin
					idle_pct = 22;
					stall_pct = 22;
				end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			if (phase == 2) hold_kick <= ~hold_kick;
			repeat (PHASE_ITEMS) begin
				make_random(mode, data);
				send_request(mode, data);
			end
			s_axis_tvalid <= 1'b0;
		end

		wait_drained();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
